### hdl/hcim_pkg.sv
// Shared types, widths and the per-level quadrant turn for the Hilbert curve mapper.
// Used by hcim_map and by the top level, hilbert_curve_index_mapper_unit.
// Depends on nothing else.
package hcim_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 32;
    localparam int CFG_W   = 5;
    // Wide enough for any curve order the register can hold, and for MAX_ORDER values up to 63.
    localparam int ORDER_W = 6;

    localparam logic [CFG_W-1:0] ORDER_RESET = CFG_W'(8);

    typedef enum logic
    {
        OP_COORD_TO_DIST = 1'b0,
        OP_DIST_TO_COORD = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                operation;
        logic [COORD_W-1:0] in_x;
        logic [COORD_W-1:0] in_y;
        logic [INDEX_W-1:0] in_index;
    } in_item_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [INDEX_W-1:0] out_index;
    } out_item_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coord_t;

    // Rotate or reflect the part of a quadrant of side 2^lvl when ry is clear. Only the low lvl bits survive.
    function automatic coord_t quad_turn(coord_t c, int lvl, logic rx, logic ry);
        logic [COORD_W-1:0] m;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        coord_t             r;
        m = '1;
        if (lvl < COORD_W)
        begin
            m = COORD_W'((32'd1 << lvl) - 32'd1);
        end
        tx = c.x & m;
        ty = c.y & m;
        if (!ry)
        begin
            tx = tx ^ ({COORD_W{rx}} & m);
            ty = ty ^ ({COORD_W{rx}} & m);
            r.x = ty;
            r.y = tx;
        end
        else
        begin
            r.x = tx;
            r.y = ty;
        end
        return r;
    endfunction

endpackage

### hdl/hilbert_curve_index_mapper_unit.sv
// Hilbert curve index mapper: a command register, one pass through the level chain in
// hcim_map, and a result register. Holds the curve order configuration register.
// Depends on hcim_pkg and hcim_map.
// An accepted beat is held in the command register; its result and done are then registered.
// Throughput: one beat per cycle; busy is always low and results cannot be held off.
// The rate is set by the single registered pass through the MAX_ORDER level chain.
// Reset: rst_n is asynchronous; it sets curve_order to 8 and clears both valid flags.
module hilbert_curve_index_mapper_unit #(
    parameter int MAX_ORDER = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  hcim_pkg::in_item_t          request,
    output logic                        done,
    output hcim_pkg::out_item_t         result,
    input  logic                        cfg_we,
    input  logic [hcim_pkg::CFG_W-1:0]  cfg_wdata
);
    import hcim_pkg::*;

    localparam logic [ORDER_W-1:0] MaxOrder = ORDER_W'(MAX_ORDER);

    logic [CFG_W-1:0]   curve_order_reg;
    logic [ORDER_W-1:0] eff_order;
    in_item_t           req_reg;
    logic               req_valid_reg;
    out_item_t          res_next;
    out_item_t          res_reg;
    logic               done_reg;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg <= ORDER_RESET;
            req_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                curve_order_reg <= cfg_wdata;
            end
            req_valid_reg <= accept;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (req_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // Orders above the supported maximum saturate.
    assign eff_order = (ORDER_W'(curve_order_reg) > MaxOrder) ? MaxOrder
                                                              : ORDER_W'(curve_order_reg);

    hcim_map #(
        .MAX_ORDER(MAX_ORDER)
    ) u_map (
        .request(req_reg),
        .order  (eff_order),
        .result (res_next)
    );

    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("accepted beat did not produce a result two cycles later");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result strobe without an accepted beat");

    a_one_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_index == '0) || (result.out_x == '0 && result.out_y == '0))
        else $error("result carries both a distance and a coordinate");

    a_order_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> (eff_order <= MaxOrder) && (eff_order <= ORDER_W'(curve_order_reg)))
        else $error("effective curve order out of range");
`endif

endmodule

### hdl/hcim_map.sv
// Combinational Hilbert mapping datapath: a chain of one bit-pair level per curve order,
// coordinate to distance from the top level down, distance to coordinate from level zero up.
// Depends on hcim_pkg.
module hcim_map #(
    parameter int MAX_ORDER = 16
) (
    input  hcim_pkg::in_item_t                 request,
    input  logic [hcim_pkg::ORDER_W-1:0]       order,
    output hcim_pkg::out_item_t                result
);
    import hcim_pkg::*;

    coord_t             c2d_c [0:MAX_ORDER];
    logic [INDEX_W-1:0] c2d_d [0:MAX_ORDER];
    coord_t             d2c_c [0:MAX_ORDER];

    assign c2d_c[0] = '{x: request.in_x, y: request.in_y};
    assign c2d_d[0] = '0;
    assign d2c_c[0] = '0;

    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_c2d
        // Stage k handles the level that is k steps below the top one.
        localparam int Lvl = MAX_ORDER - 1 - k;
        logic               rx;
        logic               ry;
        logic [INDEX_W-1:0] d_add;

        if (Lvl < COORD_W)
        begin : g_bits
            assign rx    = c2d_c[k].x[Lvl];
            assign ry    = c2d_c[k].y[Lvl];
            assign d_add = c2d_d[k] | (INDEX_W'({rx, rx ^ ry}) << (2 * Lvl));
        end
        else
        begin : g_zero
            assign rx    = 1'b0;
            assign ry    = 1'b0;
            assign d_add = c2d_d[k];
        end

        always_comb
        begin
            if (ORDER_W'(Lvl) < order)
            begin
                c2d_c[k+1] = quad_turn(c2d_c[k], Lvl, rx, ry);
                c2d_d[k+1] = d_add;
            end
            else
            begin
                c2d_c[k+1] = c2d_c[k];
                c2d_d[k+1] = c2d_d[k];
            end
        end
    end

    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_d2c
        logic   rx;
        logic   ry;
        coord_t turned;
        coord_t placed;

        if (2 * i + 1 < INDEX_W)
        begin : g_bits
            assign rx = request.in_index[2*i+1];
            assign ry = request.in_index[2*i] ^ rx;
        end
        else
        begin : g_zero
            assign rx = 1'b0;
            assign ry = 1'b0;
        end

        assign turned = quad_turn(d2c_c[i], i, rx, ry);

        // After the turn every bit from i upward is clear, so the add is a plain set.
        if (i < COORD_W)
        begin : g_place
            always_comb
            begin
                placed      = turned;
                placed.x[i] = rx;
                placed.y[i] = ry;
            end
        end
        else
        begin : g_keep
            assign placed = turned;
        end

        always_comb
        begin
            if (ORDER_W'(i) < order)
            begin
                d2c_c[i+1] = placed;
            end
            else
            begin
                d2c_c[i+1] = d2c_c[i];
            end
        end
    end

    always_comb
    begin
        if (request.operation == OP_DIST_TO_COORD)
        begin
            result.out_x     = d2c_c[MAX_ORDER].x;
            result.out_y     = d2c_c[MAX_ORDER].y;
            result.out_index = '0;
        end
        else
        begin
            result.out_x     = '0;
            result.out_y     = '0;
            result.out_index = c2d_d[MAX_ORDER];
        end
    end

endmodule
